// ----- rtl/core/dup_ack_loss_window_monitor_assert.svh -----
// Assertion macros used by the duplicate-ACK monitor sequencer RTL.
// Depends on nothing; assertions compile out when SYNTHESIS is defined.
`ifndef DUP_ACK_LOSS_WINDOW_MONITOR_ASSERT_SVH
`define DUP_ACK_LOSS_WINDOW_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define DALWM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dalwm assertion failed");
// Check a property on every rising edge, reset included.
`define DALWM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dalwm assertion failed");
`else
`define DALWM_ASSERT(label, clk, rst_n, prop)
`define DALWM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/core/dalwm_pkg.sv -----
// Shared types, constants and register indexes of the duplicate-ACK monitor.
// Depends on nothing; imported by every module of the block but the RAM.
package dalwm_pkg;

  // ACK table geometry
  localparam int unsigned ACK_ENTRIES = 1024;
  localparam int unsigned IDX_W       = $clog2(ACK_ENTRIES);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ACK_ENTRIES);

  // Header codes
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'h06;
  localparam logic        REQ_FLUSH = 1'b1;

  // Report reasons
  localparam logic END_EXPIRED = 1'b0;
  localparam logic END_FLUSH   = 1'b1;

  // Saturation limits
  localparam logic [3:0]  HIT_MAX  = 4'hF;
  localparam logic [10:0] RETR_MAX = 11'h7FF;
  localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic [31:0] LOCAL_IP_RST  = 32'hC0A8_017E;
  localparam logic [31:0] SERVER_IP_RST = 32'h8268_E62D;
  localparam logic [15:0] PORT_RST      = 16'd0;
  localparam logic [15:0] WINDOW_RST    = 16'd10;
  localparam logic [3:0]  THRESH_RST    = 4'd3;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_IP     = 3'd0,
    CFG_SERVER_IP    = 3'd1,
    CFG_WATCHED_PORT = 3'd2,
    CFG_WINDOW_SEC   = 3'd3,
    CFG_DUP_THRESH   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [31:0] server_ip;
    logic [15:0] watched_port;
    logic [15:0] window_seconds;
    logic [3:0]  dup_threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0] key;
    logic [3:0]  hits;
  } ack_entry_t;

  localparam int unsigned ENTRY_W = $bits(ack_entry_t);

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

endpackage

// ----- rtl/core/dalwm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the ACK table.
module dalwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/dalwm_cfg.sv -----
// Configuration register file of the duplicate-ACK monitor.
// Depends on dalwm_pkg for the register indexes and reset values.
module dalwm_cfg import dalwm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write one register per item; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_ip       <= LOCAL_IP_RST;
      cfg_q.server_ip      <= SERVER_IP_RST;
      cfg_q.watched_port   <= PORT_RST;
      cfg_q.window_seconds <= WINDOW_RST;
      cfg_q.dup_threshold  <= THRESH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOCAL_IP:     cfg_q.local_ip       <= cfg_data_i;
        CFG_SERVER_IP:    cfg_q.server_ip      <= cfg_data_i;
        CFG_WATCHED_PORT: cfg_q.watched_port   <= cfg_data_i[15:0];
        CFG_WINDOW_SEC:   cfg_q.window_seconds <= cfg_data_i[15:0];
        CFG_DUP_THRESH:   cfg_q.dup_threshold  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/dalwm_engine.sv -----
// Sequencer of the duplicate-ACK monitor: classify, window timing, ACK search
// and report scan over the table RAM. Depends on dalwm_pkg and the assert macros.
`include "dup_ack_loss_window_monitor_assert.svh"
module dalwm_engine import dalwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [15:0]        eth_type_i,
  input  logic [31:0]        ip_source_i,
  input  logic [31:0]        ip_dest_i,
  input  logic [7:0]         ip_proto_i,
  input  logic [15:0]        tcp_source_port_i,
  input  logic [15:0]        tcp_dest_port_i,
  input  logic [31:0]        ack_number_i,
  input  logic [31:0]        time_sec_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [10:0]        retransmit_count_o,
  output logic [31:0]        packets_seen_o,
  output logic [31:0]        window_begin_o,
  output logic               end_reason_o,
  output logic               table_overflow_o,
  output ram_req_t           ram_req_o,
  input  logic [ENTRY_W-1:0] ram_rd_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic             first_pending_q;
  logic [31:0]      window_start_q;
  logic [31:0]      pkt_q;
  logic [10:0]      retr_q;
  logic [CNT_W-1:0] used_q;
  logic             overflow_q;
  logic [CNT_W-1:0] idx_q;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [31:0]      ack_q;
  logic             up_pend_q;
  logic [31:0]      begin_q;
  logic             reason_q;
  logic             out_valid_q;
  logic [10:0]      out_retr_q;
  logic [31:0]      out_pkt_q;
  logic [31:0]      out_begin_q;
  logic             out_reason_q;
  logic             out_ovf_q;

  ack_entry_t rd_entry;
  logic       accept;
  logic       is_tcp;
  logic       up_dir;
  logic       dn_dir;
  logic       is_up;
  logic       is_dn;
  logic [32:0] diff;
  logic       close;
  logic       hit;
  logic       more;
  logic       full;
  logic       cnt_hit;
  logic       out_free;
  logic [3:0] hits_inc;

  assign rd_entry   = ack_entry_t'(ram_rd_data_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Classify the offered header
  assign is_tcp = (eth_type_i == ETH_IPV4) && (ip_proto_i == PROTO_TCP);
  assign up_dir = (ip_source_i == cfg_i.local_ip) && (ip_dest_i == cfg_i.server_ip);
  assign dn_dir = (ip_source_i == cfg_i.server_ip) && (ip_dest_i == cfg_i.local_ip);
  assign is_up  = (req_type_i != REQ_FLUSH) && is_tcp && up_dir
                  && (tcp_source_port_i == cfg_i.watched_port);
  assign is_dn  = (req_type_i != REQ_FLUSH) && is_tcp && !up_dir && dn_dir
                  && (tcp_dest_port_i == cfg_i.watched_port);

  // Window expiry: time not before start and elapsed at least the window
  assign diff  = {1'b0, time_sec_i} - {1'b0, window_start_q};
  assign close = !first_pending_q && !diff[32]
                 && (diff[31:0] >= {16'd0, cfg_i.window_seconds});

  // Table walk status
  assign hit      = rd_pend_q && (rd_entry.key == ack_q);
  assign more     = (idx_q < used_q);
  assign full     = (used_q == ENTRIES_CNT);
  assign hits_inc = (rd_entry.hits == HIT_MAX) ? HIT_MAX : rd_entry.hits + 4'd1;
  assign cnt_hit  = rd_pend_q && (rd_entry.hits >= cfg_i.dup_threshold)
                    && (retr_q != RETR_MAX);

  // Drive the table RAM port
  always_comb begin
    ram_req_o = '0;
    unique case (state_q)
      ST_SEARCH: begin
        if (hit) begin
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_addr = rd_idx_q;
          ram_req_o.wr_data = {ack_q, hits_inc};
        end else if (more) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = idx_q[IDX_W-1:0];
        end else if (!full) begin
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_addr = used_q[IDX_W-1:0];
          ram_req_o.wr_data = {ack_q, 4'd1};
        end
      end
      ST_SCAN: begin
        if (more) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = idx_q[IDX_W-1:0];
        end
      end
      ST_IDLE, ST_EMIT: ;
    endcase
  end

  // Sequencer, window state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      first_pending_q <= 1'b1;
      window_start_q  <= '0;
      pkt_q           <= '0;
      retr_q          <= '0;
      used_q          <= '0;
      overflow_q      <= 1'b0;
      idx_q           <= '0;
      rd_pend_q       <= 1'b0;
      rd_idx_q        <= '0;
      ack_q           <= '0;
      up_pend_q       <= 1'b0;
      begin_q         <= '0;
      reason_q        <= END_EXPIRED;
      out_valid_q     <= 1'b0;
      out_retr_q      <= '0;
      out_pkt_q       <= '0;
      out_begin_q     <= '0;
      out_reason_q    <= END_EXPIRED;
      out_ovf_q       <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ack_q     <= ack_number_i;
            up_pend_q <= is_up;
            idx_q     <= '0;
            rd_pend_q <= 1'b0;
            if (req_type_i == REQ_FLUSH) begin
              begin_q         <= window_start_q;
              reason_q        <= END_FLUSH;
              first_pending_q <= 1'b1;
              state_q         <= ST_SCAN;
            end else if (is_up || is_dn) begin
              if (is_dn && (pkt_q != PKT_MAX)) begin
                pkt_q <= pkt_q + 32'd1;
              end
              if (first_pending_q) begin
                window_start_q  <= time_sec_i;
                first_pending_q <= 1'b0;
                state_q         <= is_up ? ST_SEARCH : ST_IDLE;
              end else if (close) begin
                begin_q        <= window_start_q;
                window_start_q <= time_sec_i;
                reason_q       <= END_EXPIRED;
                state_q        <= ST_SCAN;
              end else begin
                state_q <= is_up ? ST_SEARCH : ST_IDLE;
              end
            end
          end
        end
        ST_SEARCH: begin
          rd_pend_q <= !hit && more;
          if (hit) begin
            state_q <= ST_IDLE;
          end else if (more) begin
            rd_idx_q  <= idx_q[IDX_W-1:0];
            idx_q     <= idx_q + CNT_W'(1);
          end else begin
            if (!full) begin
              used_q <= used_q + CNT_W'(1);
            end else begin
              overflow_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          rd_pend_q <= more;
          if (more) begin
            rd_idx_q <= idx_q[IDX_W-1:0];
            idx_q    <= idx_q + CNT_W'(1);
          end
          if (cnt_hit) begin
            retr_q <= retr_q + 11'd1;
          end
          if (!more) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_retr_q   <= retr_q;
            out_pkt_q    <= pkt_q;
            out_begin_q  <= begin_q;
            out_reason_q <= reason_q;
            out_ovf_q    <= overflow_q;
            pkt_q        <= '0;
            retr_q       <= '0;
            used_q       <= '0;
            overflow_q   <= 1'b0;
            idx_q        <= '0;
            rd_pend_q    <= 1'b0;
            state_q      <= up_pend_q ? ST_SEARCH : ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign retransmit_count_o = out_retr_q;
  assign packets_seen_o     = out_pkt_q;
  assign window_begin_o     = out_begin_q;
  assign end_reason_o       = out_reason_q;
  assign table_overflow_o   = out_ovf_q;

  // Table fill never passes its depth
  `DALWM_ASSERT_ALWAYS(a_used_bound, clk_i, used_q <= ENTRIES_CNT)
  // Overflow is only flagged with a full table
  `DALWM_ASSERT_ALWAYS(a_ovf_full, clk_i, !overflow_q || full)
  // One RAM access per cycle from the sequencer
  `DALWM_ASSERT(a_ram_excl, clk_i, rst_ni, !(ram_req_o.wr_en && ram_req_o.rd_en))
  // A report leaves the emit step as a valid result
  `DALWM_ASSERT(a_emit_valid, clk_i, rst_ni, (state_q == ST_EMIT) && out_free |=> out_valid_q)

endmodule

// ----- rtl/core/dup_ack_loss_window_monitor.sv -----
// Duplicate-ACK loss window monitor: config registers, sequencer and ACK table RAM.
// Non-matching and downlink items are taken in the idle state; an uplink item walks
// the table through the RAM read port in the search state. Window-closing and flush
// items add a report scan of the used entries and an emit step that waits for a free output.
// Reset (async, active low) restores register defaults and an empty table; the
// table RAM is not cleared, a fill count marks its valid entries.
module dup_ack_loss_window_monitor import dalwm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [15:0]          eth_type_i,
  input  logic [31:0]          ip_source_i,
  input  logic [31:0]          ip_dest_i,
  input  logic [7:0]           ip_proto_i,
  input  logic [15:0]          tcp_source_port_i,
  input  logic [15:0]          tcp_dest_port_i,
  input  logic [31:0]          ack_number_i,
  input  logic [31:0]          time_sec_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [10:0]          retransmit_count_o,
  output logic [31:0]          packets_seen_o,
  output logic [31:0]          window_begin_o,
  output logic                 end_reason_o,
  output logic                 table_overflow_o
);

  cfg_t               cfg;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rd_data;

  // Configuration registers
  dalwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer and window logic
  dalwm_engine u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .eth_type_i         (eth_type_i),
    .ip_source_i        (ip_source_i),
    .ip_dest_i          (ip_dest_i),
    .ip_proto_i         (ip_proto_i),
    .tcp_source_port_i  (tcp_source_port_i),
    .tcp_dest_port_i    (tcp_dest_port_i),
    .ack_number_i       (ack_number_i),
    .time_sec_i         (time_sec_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .retransmit_count_o (retransmit_count_o),
    .packets_seen_o     (packets_seen_o),
    .window_begin_o     (window_begin_o),
    .end_reason_o       (end_reason_o),
    .table_overflow_o   (table_overflow_o),
    .ram_req_o          (ram_req),
    .ram_rd_data_i      (ram_rd_data)
  );

  // ACK number and hit count table
  dalwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ACK_ENTRIES)
  ) u_ack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rd_data)
  );

endmodule
